// ===== rtl/core/ssrl_pkg.sv =====
// Shared constants and controller/datapath interface types for the node sort block.
package ssrl_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NUM_LINKS = 4;
  localparam int KEY_W     = 32;
  localparam int LINK_W    = 24;
  localparam int PAY_W     = 64;
  localparam int DATA_W    = KEY_W + NUM_LINKS * LINK_W + PAY_W;

  typedef enum logic [1:0] {
    KA_I,
    KA_J,
    KA_SRC
  } key_sel_e;

  typedef struct packed {
    logic     load;
    logic     close;
    key_sel_e key_sel;
    logic     rank_start;
    logic     scan;
    logic     rank_wr;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_fire;
  } dp_status_t;

endpackage

// ===== rtl/core/ssrl_ram.sv =====
// Generic single write port, single registered read port RAM.
module ssrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssrl_ctrl.sv =====
// Controller state machine sequencing load, rank computation and emit.
module ssrl_ctrl
  import ssrl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RI,
    S_RL,
    S_RS,
    S_RT,
    S_RW,
    S_EO,
    S_ES,
    S_EM,
    S_EW,
    S_EH
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_fire    = in_ready_o && in_valid_i;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.key_sel      = KA_SRC;
    case (state_q)
      S_LOAD: begin
        cmd_o.load = in_fire;
        if (in_fire && in_last_i) begin
          cmd_o.close = 1'b1;
          state_d     = S_RI;
        end
      end
      S_RI: begin
        cmd_o.key_sel = KA_I;
        state_d       = S_RL;
      end
      S_RL: begin
        cmd_o.rank_start = 1'b1;
        state_d          = S_RS;
      end
      S_RS: begin
        cmd_o.key_sel = KA_J;
        cmd_o.scan    = 1'b1;
        if (status_i.j_last) begin
          state_d = S_RT;
        end
      end
      S_RT: state_d = S_RW;
      S_RW: begin
        cmd_o.rank_wr = 1'b1;
        state_d       = status_i.i_last ? S_EO : S_RI;
      end
      S_EO: state_d = S_ES;
      S_ES: state_d = S_EM;
      S_EM: state_d = S_EW;
      S_EW: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_EH;
      end
      S_EH: begin
        if (status_i.out_fire) begin
          state_d = status_i.k_last ? S_LOAD : S_EO;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ssrl_dp.sv =====
// Datapath: node stores, rank counter, order tables, link remap and output register.
module ssrl_dp
  import ssrl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic [DATA_W-1:0]   in_data_i,
  output logic [DATA_W-1:0]   out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_last_o,
  output logic                out_ovf_o
);

  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic [IDX_W-1:0] i_q, j_q, k_q, jp_q, rank_q;
  logic             pv_q;
  logic [KEY_W-1:0] key_i_q;
  logic             out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic             out_last_q;
  logic             out_fire, full, wr_en, before_i;
  logic [CNT_W-1:0] last_idx;
  logic [IDX_W-1:0] key_raddr, src;
  logic [KEY_W-1:0] key_rdata;
  logic [PAY_W-1:0] pay_rdata;
  logic [LINK_W-1:0] link_rdata [NUM_LINKS];
  logic [IDX_W-1:0] ni_rdata [NUM_LINKS];
  logic [LINK_W-1:0] link_out [NUM_LINKS];

  assign full     = (count_q == CNT_W'(MAX_NODES));
  assign wr_en    = cmd_i.load && !full;
  assign last_idx = count_q - CNT_W'(1);
  assign out_fire = out_valid_q && out_ready_i;

  assign status_o.j_last   = ({1'b0, j_q} == last_idx);
  assign status_o.i_last   = ({1'b0, i_q} == last_idx);
  assign status_o.k_last   = ({1'b0, k_q} == last_idx);
  assign status_o.out_fire = out_fire;

  always_comb begin
    case (cmd_i.key_sel)
      KA_I:    key_raddr = i_q;
      KA_J:    key_raddr = j_q;
      default: key_raddr = src;
    endcase
  end

  ssrl_ram #(.Width(KEY_W), .Depth(MAX_NODES)) u_key_ram (
    .clk_i, .we_i(wr_en), .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(in_data_i[KEY_W-1:0]), .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  ssrl_ram #(.Width(PAY_W), .Depth(MAX_NODES)) u_pay_ram (
    .clk_i, .we_i(wr_en), .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(in_data_i[DATA_W-1 -: PAY_W]), .raddr_i(src), .rdata_o(pay_rdata)
  );

  ssrl_ram #(.Width(IDX_W), .Depth(MAX_NODES)) u_order_ram (
    .clk_i, .we_i(cmd_i.rank_wr), .waddr_i(rank_q),
    .wdata_i(i_q), .raddr_i(k_q), .rdata_o(src)
  );

  for (genvar g = 0; g < NUM_LINKS; g++) begin : g_link
    ssrl_ram #(.Width(LINK_W), .Depth(MAX_NODES)) u_link_ram (
      .clk_i, .we_i(wr_en), .waddr_i(count_q[IDX_W-1:0]),
      .wdata_i(in_data_i[KEY_W + g*LINK_W +: LINK_W]),
      .raddr_i(src), .rdata_o(link_rdata[g])
    );
    ssrl_ram #(.Width(IDX_W), .Depth(MAX_NODES)) u_index_ram (
      .clk_i, .we_i(cmd_i.rank_wr), .waddr_i(i_q),
      .wdata_i(rank_q), .raddr_i(link_rdata[g][IDX_W-1:0]), .rdata_o(ni_rdata[g])
    );
    assign link_out[g] = (link_rdata[g] < LINK_W'(count_q)) ?
                         LINK_W'(ni_rdata[g]) : link_rdata[g];
  end

  assign before_i = (key_rdata < key_i_q) || ((key_rdata == key_i_q) && (jp_q < i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rank_q      <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.scan;
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.close) begin
        i_q <= '0;
        k_q <= '0;
      end
      if (cmd_i.rank_start) begin
        j_q    <= '0;
        rank_q <= '0;
      end else if (pv_q && before_i) begin
        rank_q <= rank_q + IDX_W'(1);
      end
      if (cmd_i.scan) begin
        j_q <= j_q + IDX_W'(1);
      end
      if (cmd_i.rank_wr) begin
        i_q <= i_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
        k_q         <= k_q + IDX_W'(1);
        if (status_o.k_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_start) begin
      key_i_q <= key_rdata;
    end
    if (cmd_i.scan) begin
      jp_q <= j_q;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {pay_rdata, link_out[3], link_out[2], link_out[1], link_out[0], key_rdata};
      out_last_q <= status_o.k_last;
    end
  end

  assign out_data_o  = out_data_q;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = ovf_q;

endmodule

// ===== rtl/core/stable_sort_renumber_links.sv =====
// Top level of the stable node sort with link renumbering.
// Nodes load one per cycle until a transaction with tlast closes the set; up to 64 nodes
// are stored and further ones are dropped and reported on tuser. The sort computes each
// node's rank by scanning all stored keys through the single key memory read port. Sorted
// nodes then leave one at a time, and the next one is fetched only after the previous has
// been taken; input is held off from the closing transaction until the last sorted node
// has been taken.
module stable_sort_renumber_links
  import ssrl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // node_key, link_a, link_b, link_c, link_d, payload
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // out_key, out_link_a..out_link_d, out_payload
  output logic              m_axis_tlast,
  output logic              m_axis_tuser   // overflowed
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ssrl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .status_i(status), .cmd_o(cmd)
  );

  ssrl_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .in_data_i(s_axis_tdata), .out_data_o(m_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_o(m_axis_tlast), .out_ovf_o(m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_no_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during emit");
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input not stalled after closing transaction");
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened after final transaction");
`endif

endmodule
